[rtl/core/sem_pkg.sv]
// Shared constants and control types for the Sobel edge magnitude unit.
package sem_pkg;

  // Field and register widths.
  localparam int PIX_W   = 8;
  localparam int IMG_W_W = 11;
  localparam int IMG_H_W = 16;
  localparam int THR_W   = 8;
  localparam int GRAD_W  = 12;
  localparam int SUM_W   = 21;
  localparam int ROOT_W  = 11;

  // Sizes and reset values.
  localparam int MAX_WIDTH_DEF = 1024;
  localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd640;
  localparam logic [IMG_H_W-1:0] IMG_H_RST = 16'd480;
  localparam logic [THR_W-1:0]   THR_RST   = 8'd0;
  localparam logic [ROOT_W-1:0]  SAT_MAX   = 11'd255;
  localparam logic [IMG_H_W-1:0] MIN_H     = 16'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_IMG_W = 2'd0;
  localparam logic [1:0] REG_IMG_H = 2'd1;
  localparam logic [1:0] REG_THR   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic win_upd;
    logic grad;
    logic root_start;
    logic load_out;
    logic zero_val;
    logic last;
  } sem_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic root_done;
    logic out_free;
  } sem_stat_t;

endpackage

[rtl/core/sem_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/sem_isqrt.sv]
// Iterative floor square root, one result bit per cycle.
module sem_isqrt
  import sem_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  value,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] res_r, res_nxt;
  logic [SUM_W-1:0] bit_r, bit_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SUM_W-1:0] trial;

  // One restoring step per cycle, two radicand bits at a time.
  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = res_r + bit_r;
    if (start) begin
      rem_nxt  = value;
      res_nxt  = '0;
      bit_nxt  = {1'b1, {(SUM_W-1){1'b0}}};
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign root = res_r[ROOT_W-1:0];
  assign done = done_r;

endmodule

[rtl/core/sem_datapath.sv]
// Line buffers, 3x3 window, gradient, magnitude and output register.
module sem_datapath
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sem_cmd_t                     cmd,
  output sem_stat_t                    stat,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_addr,
  input  logic                         col_hit,
  input  logic [PIX_W-1:0]             in_pixel,
  input  logic                         in_flush,
  input  logic [THR_W-1:0]             threshold,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [PIX_W-1:0]             out_value,
  output logic                         out_last
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0]  pix_r;
  logic [AW-1:0]     addr_r;
  logic              hit_r;
  logic [PIX_W-1:0]  win_r [9];
  logic [PIX_W-1:0]  up_rd, mid_rd, up_val, mid_val;
  logic [GRAD_W-1:0] gx_r, gy_r, gx, gy;
  logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
  logic [SUM_W-1:0]  sum;
  logic [ROOT_W-1:0] root;
  logic              root_done;
  logic [PIX_W-1:0]  res_val;
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_value_r;
  logic              out_last_r;
  logic              out_free;

  // Line buffers: both read at the incoming column, written in the cycle after.
  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(cmd.win_upd), .waddr(addr_r), .wdata(mid_val),
    .raddr(col_addr), .rdata(up_rd)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .we(cmd.win_upd), .waddr(addr_r), .wdata(pix_r),
    .raddr(col_addr), .rdata(mid_rd)
  );

  // Entries beyond the written prefix are masked to zero.
  assign up_val  = hit_r ? up_rd  : '0;
  assign mid_val = hit_r ? mid_rd : '0;

  // Latch the accepted word.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r  <= in_flush ? '0 : in_pixel;
      addr_r <= col_addr;
      hit_r  <= col_hit;
    end
  end

  // Slide the window one column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.win_upd) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= up_val;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= mid_val;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= pix_r;
    end
  end

  // Sobel gradients.
  assign gx = (GRAD_W'(win_r[2]) + (GRAD_W'(win_r[5]) << 1) + GRAD_W'(win_r[8]))
            - (GRAD_W'(win_r[0]) + (GRAD_W'(win_r[3]) << 1) + GRAD_W'(win_r[6]));
  assign gy = (GRAD_W'(win_r[6]) + (GRAD_W'(win_r[7]) << 1) + GRAD_W'(win_r[8]))
            - (GRAD_W'(win_r[0]) + (GRAD_W'(win_r[1]) << 1) + GRAD_W'(win_r[2]));

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      gx_r <= gx;
      gy_r <= gy;
    end
  end

  // Sum of squares feeds the root unit directly.
  assign gx_sq = $signed(gx_r) * $signed(gx_r);
  assign gy_sq = $signed(gy_r) * $signed(gy_r);
  assign sum   = SUM_W'(gx_sq) + SUM_W'(gy_sq);

  sem_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.root_start), .value(sum),
    .root(root), .done(root_done)
  );

  // Threshold first, then saturate.
  always_comb begin
    if (cmd.zero_val || (root < ROOT_W'(threshold))) begin
      res_val = '0;
    end else if (root > SAT_MAX) begin
      res_val = SAT_MAX[PIX_W-1:0];
    end else begin
      res_val = root[PIX_W-1:0];
    end
  end

  // Output register.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.load_out) begin
      out_value_r <= res_val;
      out_last_r  <= cmd.last;
    end
  end

  assign stat.root_done = root_done;
  assign stat.out_free  = out_free;
  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_last       = out_last_r;

endmodule

[rtl/core/sem_ctrl.sv]
// Controller: raster position counters and the per-word sequencer.
module sem_ctrl
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [IMG_W_W-1:0]           img_width,
  input  logic [IMG_H_W-1:0]           img_height,
  input  sem_stat_t                    stat,
  output sem_cmd_t                     cmd,
  output logic [$clog2(MAX_WIDTH)-1:0] col_addr,
  output logic                         col_hit
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = ($clog2(MAX_WIDTH + 2) > IMG_W_W) ? $clog2(MAX_WIDTH + 2) : IMG_W_W;
  localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);
  localparam logic [CW-1:0] MINW = CW'(3);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_GRAD = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CW-1:0]      in_col_r, in_col_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      warm_r, warm_nxt;
  logic [CW-1:0]      out_col_r, out_col_nxt;
  logic [IMG_H_W-1:0] out_row_r, out_row_nxt;
  logic               has_res_r, has_res_nxt;
  logic               border_r, border_nxt;
  logic               last_r, last_nxt;
  logic [CW-1:0]      cfg_w, w, col, col_inc;
  logic [IMG_H_W-1:0] h, h_m1;
  logic               accept, row_end, col_end, last_px;

  // Clamped frame geometry.
  assign cfg_w = CW'(img_width);
  always_comb begin
    if (cfg_w < MINW) begin
      w = MINW;
    end else if (cfg_w > MAXW) begin
      w = MAXW;
    end else begin
      w = cfg_w;
    end
  end
  assign h    = (img_height < MIN_H) ? MIN_H : img_height;
  assign h_m1 = h - 16'd1;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Column of the incoming pixel and the written prefix of the line buffers.
  assign col      = (in_col_r >= w) ? '0 : in_col_r;
  assign col_inc  = col + CW'(1);
  assign col_addr = col[AW-1:0];
  assign col_hit  = col < fill_r;

  assign row_end = out_row_r >= h_m1;
  assign col_end = out_col_r >= (w - CW'(1));
  assign last_px = row_end && col_end;

  // Position counters advance when a word is accepted.
  always_comb begin
    in_col_nxt  = in_col_r;
    fill_nxt    = fill_r;
    warm_nxt    = warm_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    has_res_nxt = has_res_r;
    border_nxt  = border_r;
    last_nxt    = last_r;
    if (accept) begin
      in_col_nxt = (col_inc >= w) ? '0 : col_inc;
      if (col_inc > fill_r) begin
        fill_nxt = col_inc;
      end
      if (warm_r < (w + CW'(1))) begin
        warm_nxt    = warm_r + CW'(1);
        has_res_nxt = 1'b0;
      end else begin
        has_res_nxt = 1'b1;
        border_nxt  = (out_row_r == '0) || row_end || (out_col_r == '0) || col_end;
        last_nxt    = last_px;
        if (last_px) begin
          out_row_nxt = '0;
          out_col_nxt = '0;
          in_col_nxt  = '0;
          warm_nxt    = '0;
        end else if (col_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 16'd1;
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  // Sequencer for one word.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.accept   = accept;
    cmd.zero_val = border_r;
    cmd.last     = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.win_upd = 1'b1;
        if (!has_res_r) begin
          state_nxt = S_IDLE;
        end else if (border_r) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_GRAD;
        end
      end
      S_GRAD: begin
        cmd.grad  = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.root_start = 1'b1;
        state_nxt      = S_ROOT;
      end
      S_ROOT: begin
        if (stat.root_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      in_col_r  <= '0;
      fill_r    <= '0;
      warm_r    <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      has_res_r <= 1'b0;
      border_r  <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_col_r  <= in_col_nxt;
      fill_r    <= fill_nxt;
      warm_r    <= warm_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      has_res_r <= has_res_nxt;
      border_r  <= border_nxt;
      last_r    <= last_nxt;
    end
  end

endmodule

[rtl/core/sobel_edge_magnitude_threshold_unit.sv]
// Top level of the Sobel edge magnitude unit with threshold.
//
// Takes 8-bit grey pixels in raster order and returns one edge pixel per input
// once image_width+1 words have arrived; after each frame the source sends
// image_width+1 words with tuser (flush) set to drain the last row and column.
// Border pixels come out as 0, interior pixels as floor(sqrt(Gx^2+Gy^2)),
// forced to 0 below edge_threshold and saturated at 255; tlast marks the last
// pixel of a frame. One word is handled at a time: warm-up words only shift
// the window, border pixels go to the output, interior pixels also pass the
// gradient and 11-step square root. Line buffers need no clearing after reset.
module sobel_edge_magnitude_threshold_unit
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  input  logic        in_tuser,   // [0] flush
  // Result words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] edge_value
  output logic        out_tlast,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [IMG_W_W-1:0] img_w_r;
  logic [IMG_H_W-1:0] img_h_r;
  logic [THR_W-1:0]   thr_r;
  logic [1:0]         reg_idx;
  logic               cfg_wr;
  sem_cmd_t           cmd;
  sem_stat_t          stat;
  logic [$clog2(MAX_WIDTH)-1:0] col_addr;
  logic               col_hit;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_W_RST;
      img_h_r <= IMG_H_RST;
      thr_r   <= THR_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IMG_W: img_w_r <= cfg_pwdata[IMG_W_W-1:0];
        REG_IMG_H: img_h_r <= cfg_pwdata[IMG_H_W-1:0];
        REG_THR:   thr_r   <= cfg_pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMG_W: cfg_prdata = 32'(img_w_r);
      REG_IMG_H: cfg_prdata = 32'(img_h_r);
      REG_THR:   cfg_prdata = 32'(thr_r);
      default:   cfg_prdata = '0;
    endcase
  end

  sem_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .img_width(img_w_r), .img_height(img_h_r), .stat(stat), .cmd(cmd),
    .col_addr(col_addr), .col_hit(col_hit)
  );

  sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .col_addr(col_addr), .col_hit(col_hit),
    .in_pixel(in_tdata), .in_flush(in_tuser), .threshold(thr_r),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_value(out_tdata), .out_last(out_tlast)
  );

endmodule

[tb/tb_sobel_edge_magnitude_threshold_unit.sv]
// Self-checking testbench for the Sobel edge magnitude unit with threshold.
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude_threshold_unit;
  import sem_pkg::*;

  localparam int MAXW = 1024;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sobel_edge_magnitude_threshold_unit dut (.*);

  always #10 clk = ~clk;

  // Predictor state: registers, line buffers, window and frame counters.
  logic [IMG_W_W-1:0] pm_width;
  logic [IMG_H_W-1:0] pm_height;
  logic [THR_W-1:0]   pm_thr;
  logic [7:0]         line_up [MAXW];
  logic [7:0]         line_mid [MAXW];
  logic [7:0]         win [9];
  int unsigned        warm_cnt, row_pos, col_pos, in_pos;

  typedef struct packed {
    logic [7:0] edge_value;
    logic       last_of_frame;
  } edge_pix_t;
  edge_pix_t edge_q[$];

  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_cycles = 0;

  function automatic int unsigned isqrt(int unsigned v);
    int unsigned r;
    r = 0;
    for (int b = 10; b >= 0; b--) begin
      if ((r + (1 << b)) * (r + (1 << b)) <= v) r = r + (1 << b);
    end
    return r;
  endfunction

  // Advances the predictor by one input word and queues any edge pixel.
  task automatic predict_edge(input logic [7:0] pix, input logic flush);
    int unsigned w, h, val;
    int gx, gy;
    logic [7:0] p;
    logic last;
    w = (pm_width < 3) ? 3 : (pm_width > MAXW ? MAXW : pm_width);
    h = (pm_height < 3) ? 3 : pm_height;
    p = flush ? 8'd0 : pix;
    if (in_pos >= w) in_pos = 0;
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = line_up[in_pos];
    win[5] = line_mid[in_pos];
    win[8] = p;
    line_up[in_pos] = line_mid[in_pos];
    line_mid[in_pos] = p;
    in_pos = (in_pos + 1 >= w) ? 0 : in_pos + 1;
    if (warm_cnt < w + 1) begin
      warm_cnt++;
      return;
    end
    if (row_pos == 0 || row_pos >= h - 1 || col_pos == 0 || col_pos >= w - 1) begin
      val = 0;
    end else begin
      gx = (int'(win[2]) + 2*win[5] + win[8]) - (int'(win[0]) + 2*win[3] + win[6]);
      gy = (int'(win[6]) + 2*win[7] + win[8]) - (int'(win[0]) + 2*win[1] + win[2]);
      val = isqrt(gx*gx + gy*gy);
      if (val < pm_thr) val = 0;
      else if (val > 255) val = 255;
    end
    last = (row_pos >= h - 1) && (col_pos >= w - 1);
    if (last) begin
      row_pos = 0; col_pos = 0; in_pos = 0; warm_cnt = 0;
    end else if (col_pos >= w - 1) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
    edge_q.push_back('{edge_value: val[7:0], last_of_frame: last});
  endtask

  // Sends one word, waiting out random idle cycles first.
  task automatic send_pixel(input logic [7:0] pix, input logic flush);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= flush;
    predict_edge(pix, flush);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (idx == REG_IMG_W) pm_width = val[IMG_W_W-1:0];
    else if (idx == REG_IMG_H) pm_height = val[IMG_H_W-1:0];
    else if (idx == REG_THR) pm_thr = val[THR_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h, input int thr);
    wait_drained();
    write_reg(REG_IMG_W, w);
    write_reg(REG_IMG_H, h);
    write_reg(REG_THR, thr);
  endtask

  // Sends a whole frame followed by its flush words; kind picks the content.
  task automatic send_frame(input int kind);
    int unsigned w, h;
    logic [7:0] v;
    w = (pm_width < 3) ? 3 : (pm_width > MAXW ? MAXW : pm_width);
    h = (pm_height < 3) ? 3 : pm_height;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        case (kind)
          0: v = 8'($urandom_range(255));
          1: v = (c >= w/2) ? 8'hFF : 8'h00;
          2: v = (r >= h/2) ? 8'hFF : 8'h00;
          default: v = ((r + c) % 2) ? 8'hFF : 8'h00;
        endcase
        send_pixel(v, (kind == 0) && ($urandom_range(19) == 0));
      end
    end
    for (int i = 0; i <= w; i++) send_pixel(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic test_directed();
    set_frame(3, 3, 0);
    send_frame(1);
    send_frame(3);
    set_frame(4, 3, 255);
    send_frame(2);
  endtask

  task automatic test_thresholds();
    set_frame(5, 4, 0);
    send_frame(0);
    set_frame(6, 5, 128);
    send_frame(0);
    set_frame(2, 1, 255);
    send_frame(1);
  endtask

  task automatic test_idle_phases();
    set_frame(8, 6, 40);
    send_idle_pct = 50;
    send_frame(0);
    send_idle_pct = 0; recv_stall_pct = 50;
    send_frame(0);
    send_idle_pct = 22; recv_stall_pct = 22;
    set_frame(7, 5, 0);
    send_frame(0);
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_frame(6, 4, 10);
    hold_cycles = 300;
    send_frame(0);
    wait_drained();
    send_frame(0);
  endtask

  task automatic test_random();
    int n;
    n = 0;
    while (n < 260) begin
      set_frame($urandom_range(10, 3), $urandom_range(6, 3), $urandom_range(255));
      send_idle_pct = $urandom_range(1) * 30;
      recv_stall_pct = $urandom_range(1) * 30;
      send_frame($urandom_range(3) == 0 ? 1 + $urandom_range(2) : 0);
      n += int'(pm_width) * int'(pm_height) + int'(pm_width) + 1;
    end
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  // Receiver ready: long hold-off on request, else random stalls.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compares each accepted edge pixel against the oldest prediction.
  always @(posedge clk) begin
    edge_pix_t exp_pix;
    if (rst_n && out_tvalid && out_tready) begin
      if (edge_q.size() == 0) begin
        $error("unexpected edge pixel %0d", out_tdata);
        errors++;
      end else begin
        exp_pix = edge_q.pop_front();
        if (out_tdata !== exp_pix.edge_value) begin
          $error("edge_value expected %0d got %0d", exp_pix.edge_value, out_tdata);
          errors++;
        end
        if (out_tlast !== exp_pix.last_of_frame) begin
          $error("last_of_frame expected %0d got %0d", exp_pix.last_of_frame, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    pm_width = IMG_W_RST; pm_height = IMG_H_RST; pm_thr = THR_RST;
    for (int i = 0; i < MAXW; i++) begin
      line_up[i] = '0;
      line_mid[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    warm_cnt = 0; row_pos = 0; col_pos = 0; in_pos = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_idle_phases();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0 && edge_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
